@@ rtl/core/sorted_list_predecessor_search_macros.svh @@
// assertion macros used by the checker file
`ifndef SORTED_LIST_PREDECESSOR_SEARCH_MACROS_SVH
`define SORTED_LIST_PREDECESSOR_SEARCH_MACROS_SVH

// same-cycle implication, disabled during reset
`define SLPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SLPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/slps_pkg.sv @@
// ----------------------------------------------------------------------------
// slps_pkg
// shared widths, codes and the memory request type of the predecessor search
// ----------------------------------------------------------------------------
package slps_pkg;

  localparam int IDX_W  = 10;
  localparam int LEN_W  = 11;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 7;

  // last probe number before the search is cut off (80 probes)
  localparam logic [CNT_W-1:0] PROBE_LAST = 7'd79;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] ST_FOUND = 2'd0;
  localparam logic [STAT_W-1:0] ST_BELOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    val_t wdata;
    idx_t raddr;
  } mem_req_t;

endpackage

@@ rtl/core/slps_store.sv @@
// ----------------------------------------------------------------------------
// slps_store
// list memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module slps_store
  import slps_pkg::*;
#(
  parameter int ENTRIES = 1024
) (
  input  logic     clk,
  input  mem_req_t mem_req,
  output val_t     rdata
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  val_t mem [ENTRIES];

  // writes past the memory depth are dropped
  always_ff @(posedge clk) begin
    if (mem_req.we && (int'(mem_req.waddr) < ENTRIES)) begin
      mem[AW'(mem_req.waddr)] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[AW'(mem_req.raddr)];
  end

endmodule

@@ rtl/core/slps_seq.sv @@
// ----------------------------------------------------------------------------
// slps_seq
// search sequencer: one comparator and one midpoint adder reused per probe
// ----------------------------------------------------------------------------
module slps_seq
  import slps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  idx_t              entry_index,
  input  val_t              value,
  input  idx_t              lower_bound,
  input  idx_t              upper_bound,
  input  logic [LEN_W-1:0]  eff_len,
  output mem_req_t          mem_req,
  input  val_t              rdata,
  output logic              out_valid,
  input  logic              out_ready,
  output idx_t              found_index,
  output logic [STAT_W-1:0] status
);

  typedef enum logic [2:0] {S_IDLE, S_LO, S_PROBE, S_NEXT, S_DONE} state_t;

  state_t            state, state_next;
  val_t              key, key_next;
  idx_t              lo, lo_next, hi, hi_next, idx, idx_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  idx_t              res_found, res_found_next;
  logic [STAT_W-1:0] res_status, res_status_next;
  logic              out_valid_next;
  idx_t              found_index_next;
  logic [STAT_W-1:0] status_next;

  // shared units
  logic              key_lt;
  idx_t              mid_a, mid_b, mid;
  logic              mid_rnd;
  logic [IDX_W:0]    mid_sum;
  logic              bad_bounds;

  assign key_lt  = key < rdata;
  assign mid_sum = {1'b0, mid_a} + {1'b0, mid_b} + {{IDX_W{1'b0}}, mid_rnd};
  assign mid     = mid_sum[IDX_W:1];

  assign bad_bounds = (lower_bound > upper_bound) || ({1'b0, upper_bound} >= eff_len);
  assign in_ready   = (state == S_IDLE);

  always_comb begin
    state_next       = state;
    key_next         = key;
    lo_next          = lo;
    hi_next          = hi;
    idx_next         = idx;
    cnt_next         = cnt;
    res_found_next   = res_found;
    res_status_next  = res_status;
    out_valid_next   = out_valid && !out_ready;
    found_index_next = found_index;
    status_next      = status;
    mid_a            = lower_bound;
    mid_b            = upper_bound;
    mid_rnd          = 1'b1;
    mem_req.we       = 1'b0;
    mem_req.waddr    = entry_index;
    mem_req.wdata    = value;
    mem_req.raddr    = idx;

    unique case (state)
      S_IDLE: begin
        mem_req.raddr = lower_bound;
        if (in_valid) begin
          if (cmd == CMD_LOAD) begin
            mem_req.we = 1'b1;
          end else begin
            key_next = value;
            lo_next  = lower_bound;
            hi_next  = upper_bound;
            idx_next = mid;
            cnt_next = '0;
            if (bad_bounds) begin
              res_found_next  = ({1'b0, lower_bound} < eff_len) ? lower_bound
                                                                : IDX_W'(eff_len - 1'b1);
              res_status_next = ST_BAD;
              state_next      = S_DONE;
            end else begin
              state_next = S_LO;
            end
          end
        end
      end
      S_LO: begin
        if (key_lt) begin
          res_found_next  = lo;
          res_status_next = ST_BELOW;
          state_next      = S_DONE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        mid_a   = lo;
        mid_b   = idx;
        mid_rnd = 1'b0;
        if (key_lt) begin
          // entry too big: pull upper bound down, floor midpoint
          hi_next  = idx;
          idx_next = mid;
          if (cnt == PROBE_LAST) begin
            res_found_next  = mid;
            res_status_next = ST_FOUND;
            state_next      = S_DONE;
          end else begin
            cnt_next      = cnt + 1'b1;
            mem_req.raddr = mid;
          end
        end else if (idx == hi) begin
          res_found_next  = idx;
          res_status_next = ST_FOUND;
          state_next      = S_DONE;
        end else begin
          mem_req.raddr = idx + 1'b1;
          state_next    = S_NEXT;
        end
      end
      S_NEXT: begin
        mid_a   = idx;
        mid_b   = hi;
        mid_rnd = 1'b1;
        if (key_lt) begin
          res_found_next  = idx;
          res_status_next = ST_FOUND;
          state_next      = S_DONE;
        end else begin
          // next entry still fits: push lower bound up, ceiling midpoint
          lo_next  = idx;
          idx_next = mid;
          if (cnt == PROBE_LAST) begin
            res_found_next  = mid;
            res_status_next = ST_FOUND;
            state_next      = S_DONE;
          end else begin
            cnt_next      = cnt + 1'b1;
            mem_req.raddr = mid;
            state_next    = S_PROBE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next   = 1'b1;
          found_index_next = res_found;
          status_next      = res_status;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    key         <= key_next;
    lo          <= lo_next;
    hi          <= hi_next;
    idx         <= idx_next;
    cnt         <= cnt_next;
    res_found   <= res_found_next;
    res_status  <= res_status_next;
    found_index <= found_index_next;
    status      <= status_next;
  end

endmodule

@@ rtl/core/sorted_list_predecessor_search.sv @@
// ----------------------------------------------------------------------------
// sorted_list_predecessor_search
// binary search for the last list entry not greater than a key
// ----------------------------------------------------------------------------
// The block keeps a list of signed 32-bit entries in a single-port-read
// memory. A load word (cmd 0) writes one entry and returns nothing; the
// block stays ready. A query word (cmd 1) searches the inclusive range
// lower_bound..upper_bound for the last index whose entry is not greater
// than the key and returns one word. Status 0 is a hit, status 1 means the key
// is below the entry at lower_bound (found_index is lower_bound), status 2
// flags inverted bounds or an upper bound at or past list_length, with
// found_index being lower_bound clamped into the list. A query is accepted,
// then the entry at lower_bound is checked, then each probe that moves the
// upper bound takes one read and each probe that moves the lower bound also
// reads the next entry; finally the result is posted, holding while a
// previous result word is stalled. Each probe waits on the registered memory
// read. Unsorted lists stop after 80 probes. Query bounds must only cover
// written entries. list_length may be changed only while idle; a value of 0
// acts as 1, values above ENTRIES act as ENTRIES.
module sorted_list_predecessor_search
  import slps_pkg::*;
#(
  parameter int ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_data,
  // input words
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              cmd,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic signed [VAL_W-1:0] value,
  input  logic [IDX_W-1:0]  lower_bound,
  input  logic [IDX_W-1:0]  upper_bound,
  // result words
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  found_index,
  output logic [STAT_W-1:0] status
);

  // longest list the 11-bit length register can name, capped by the depth
  localparam int LEN_CAP = (ENTRIES > 2047) ? 2047 : ENTRIES;

  logic [LEN_W-1:0] list_length;
  logic [LEN_W-1:0] eff_len;
  mem_req_t         mem_req;
  val_t             rdata;

  // length register, written straight from the config port
  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= LEN_RESET;
    end else if (cfg_we) begin
      list_length <= cfg_data;
    end
  end

  // zero length reads as one, oversize length reads as the memory depth
  always_comb begin
    if (list_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (list_length > LEN_W'(LEN_CAP)) begin
      eff_len = LEN_W'(LEN_CAP);
    end else begin
      eff_len = list_length;
    end
  end

  // list storage
  slps_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  // search sequencer with the shared compare and midpoint units
  slps_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .entry_index (entry_index),
    .value       (value),
    .lower_bound (lower_bound),
    .upper_bound (upper_bound),
    .eff_len     (eff_len),
    .mem_req     (mem_req),
    .rdata       (rdata),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found_index (found_index),
    .status      (status)
  );

endmodule

@@ rtl/core/slps_checker.sv @@
// ----------------------------------------------------------------------------
// slps_checker
// port-level checks of the predecessor search, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_list_predecessor_search_macros.svh"

module slps_checker
  import slps_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [IDX_W-1:0]  found_index,
  input logic [STAT_W-1:0] status
);

  // a taken query word drops ready and occupies the block
  `SLPS_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (cmd == CMD_QUERY), !in_ready, "query did not drop ready")

  // a load word never blocks the next word
  `SLPS_ASSERT_NEXT(a_load_ready, in_valid && in_ready && (cmd == CMD_LOAD), in_ready, "load dropped ready")

  // a stalled result word holds
  `SLPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(found_index) && $stable(status), "result word changed while stalled")

  // a result word never rises while a word is taken with ready already high before it
  `SLPS_ASSERT_SAME(a_no_result_on_query, $rose(out_valid), !(in_valid && in_ready && $past(in_ready)), "result appeared without a finished query")

endmodule

bind sorted_list_predecessor_search slps_checker u_slps_checker (.*);
